// ----- hdl/maf_pkg.sv -----
// Shared types and constants for the attitude filter.
// Used by every module of the block; depends on nothing.
package maf_pkg;

    localparam int unsigned STAMP_W  = 63;
    localparam int unsigned DELTA_W  = 30;
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_AW  = 1;
    localparam int unsigned FIFO_CW  = 2;

    localparam logic [DELTA_W-1:0] NS_PER_S = 30'd1000000000;
    localparam logic signed [31:0] Q30_ONE  = 32'sh4000_0000;

    localparam logic [15:0]        PROP_GAIN_RST     = 16'd8192;
    localparam logic [15:0]        INTEGRAL_GAIN_RST = 16'd0;
    localparam logic [DELTA_W-1:0] MAX_GAP_RST       = 30'd100000000;

    typedef enum logic [1:0] {
        REG_PROP_GAIN     = 2'd0,
        REG_INTEGRAL_GAIN = 2'd1,
        REG_MAX_GAP       = 2'd2
    } maf_reg_t;

    typedef struct packed {
        logic               updated;
        logic [DELTA_W-1:0] delta;
        logic [2:0][31:0]   gyro;
        logic [2:0][31:0]   accel;
    } maf_item_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integral_gain;
    } maf_gain_t;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } maf_ds_req_t;

endpackage

// ----- hdl/mahony_attitude_filter.sv -----
// Top level of the fixed-point gyro/accel attitude filter.
// Holds the configuration registers and wires front end, queue and core.
// Depends on maf_pkg, maf_front, maf_fifo and maf_core.
//
// Usage:
//   s_* carries one IMU sample per beat (stamp, gyro, accel); m_* returns
//   one beat per sample with the attitude quaternion in Q2.30 and, in
//   m_tuser, whether the attitude advanced. The APB port sets the gains
//   and the largest accepted sample interval; write it only while idle.
//   A sample that does not advance the attitude goes straight from the core's
//   idle state to its output state. An advancing sample takes longer with a
//   nonzero accel vector than with a zero one, and longer again for each
//   right shift of the quaternion renormalization (usually none). Its time
//   is set by the shared multiplier (up to 46 products per sample) and by
//   the iterative divide/root unit, which runs the divides and square roots.
//   A two-entry queue lets up to two samples wait while one is in work, and
//   the core starts the next sample while a result beat is still held.
//   A stalled m_tready holds the result beat; the core then waits before
//   storing the next one, and s_tready drops once the queue is full.
//   Reset restores identity attitude, zero integral terms, no previous
//   stamp and the default register values.
module mahony_attitude_filter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // stamp_ns[62:0], gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, pad
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_w[31:0], quat_x, quat_y, quat_z
    output logic [127:0] m_tdata,
    // updated
    output logic         m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import maf_pkg::*;

    logic [15:0]        prop_gain_reg;
    logic [15:0]        integral_gain_reg;
    logic [DELTA_W-1:0] max_gap_reg;
    logic               cfg_wr;
    maf_gain_t          gain;
    logic               push;
    maf_item_t          push_data;
    logic               full;
    logic               pop;
    maf_item_t          head;
    logic               empty;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integral_gain_reg <= INTEGRAL_GAIN_RST;
            max_gap_reg       <= MAX_GAP_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PROP_GAIN:     prop_gain_reg     <= pwdata[15:0];
                REG_INTEGRAL_GAIN: integral_gain_reg <= pwdata[15:0];
                REG_MAX_GAP:       max_gap_reg       <= pwdata[DELTA_W-1:0];
                default:           prop_gain_reg     <= prop_gain_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PROP_GAIN:     prdata = {16'b0, prop_gain_reg};
            REG_INTEGRAL_GAIN: prdata = {16'b0, integral_gain_reg};
            REG_MAX_GAP:       prdata = {2'b0, max_gap_reg};
            default:           prdata = '0;
        endcase
    end

    assign gain.prop_gain     = prop_gain_reg;
    assign gain.integral_gain = integral_gain_reg;

    maf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .max_gap   (max_gap_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    maf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (head),
        .empty     (empty)
    );

    maf_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .gain     (gain),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- hdl/maf_fifo.sv -----
// Two-entry queue between the sample front end and the filter core.
// Depends on maf_pkg for the queued item type.
module maf_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  maf_pkg::maf_item_t push_data,
    output logic               full,
    input  logic               pop,
    output maf_pkg::maf_item_t pop_data,
    output logic               empty
);
    import maf_pkg::*;

    maf_item_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;

    assign full     = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/maf_front.sv -----
// Sample front end: accepts beats, derives the sample interval from the
// previous stamp and queues the item. Depends on maf_pkg.
module maf_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // stamp_ns[62:0], gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, pad
    input  logic [255:0]                s_tdata,
    input  logic [maf_pkg::DELTA_W-1:0] max_gap,
    output logic                        push,
    output maf_pkg::maf_item_t          push_data,
    input  logic                        full
);
    import maf_pkg::*;

    logic [STAMP_W-1:0] prev_stamp_reg;
    logic               have_prev_reg;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] diff;
    logic               later;
    logic               in_gap;
    logic               usable;

    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    assign stamp  = s_tdata[STAMP_W-1:0];
    assign diff   = stamp - prev_stamp_reg;
    assign later  = have_prev_reg && (stamp > prev_stamp_reg);
    assign in_gap = (diff[STAMP_W-1:DELTA_W] == '0) && (diff[DELTA_W-1:0] <= max_gap);
    assign usable = later && in_gap;

    always_comb begin
        push_data.updated  = usable;
        push_data.delta    = usable ? diff[DELTA_W-1:0] : '0;
        push_data.gyro[0]  = s_tdata[94:63];
        push_data.gyro[1]  = s_tdata[126:95];
        push_data.gyro[2]  = s_tdata[158:127];
        push_data.accel[0] = s_tdata[190:159];
        push_data.accel[1] = s_tdata[222:191];
        push_data.accel[2] = s_tdata[254:223];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_stamp_reg <= '0;
            have_prev_reg  <= 1'b0;
        end else if (push) begin
            prev_stamp_reg <= stamp;
            have_prev_reg  <= 1'b1;
        end
    end

endmodule

// ----- hdl/maf_divsqrt.sv -----
// Iterative unit: 64-by-32 unsigned divide (4 quotient bits a cycle) or
// 64-bit integer square root (2 result bits a cycle). Depends on maf_pkg.
module maf_divsqrt (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  maf_pkg::maf_ds_req_t req,
    input  logic [63:0]          num,
    input  logic [31:0]          den,
    output logic                 done,
    output logic [31:0]          result
);
    import maf_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic        sqrt_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] one_reg;

    logic [31:0] rem_next;
    logic [31:0] quo_next;
    logic [63:0] x_next;
    logic [63:0] res_next;
    logic [63:0] one_next;
    logic        last;

    always_comb begin
        logic [32:0] t;
        logic [63:0] ro;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int k = 0; k < 4; k++) begin
            t        = {rem_next, quo_next[31]};
            quo_next = {quo_next[30:0], 1'b0};
            if (t >= {1'b0, den_reg}) begin
                t           = t - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = t[31:0];
        end
        x_next   = x_reg;
        res_next = res_reg;
        one_next = one_reg;
        for (int k = 0; k < 2; k++) begin
            ro = res_next + one_next;
            if (x_next >= ro) begin
                x_next   = x_next - ro;
                res_next = (res_next >> 1) + one_next;
            end else begin
                res_next = res_next >> 1;
            end
            one_next = one_next >> 2;
        end
    end

    assign last   = sqrt_reg ? (cnt_reg == 4'd15) : (cnt_reg == 4'd7);
    assign done   = done_reg;
    assign result = sqrt_reg ? res_reg[31:0] : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sqrt_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                sqrt_reg <= req.is_sqrt;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= num[63:32];
            quo_reg <= num[31:0];
            den_reg <= den;
            x_reg   <= num;
            res_reg <= '0;
            one_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (sqrt_reg) begin
                x_reg   <= x_next;
                res_reg <= res_next;
                one_reg <= one_next;
            end else begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
        end
    end

endmodule

// ----- hdl/maf_core.sv -----
// Filter core: microcoded sequence over one shared multiplier plus the
// divide/root unit; holds attitude and integral state and the result beat.
// Depends on maf_pkg and maf_divsqrt.
module maf_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  maf_pkg::maf_gain_t gain,
    output logic               pop,
    input  maf_pkg::maf_item_t head,
    input  logic               empty,
    output logic               m_tvalid,
    input  logic               m_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [127:0]       m_tdata,
    // updated
    output logic               m_tuser
);
    import maf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DT, S_MUL, S_ACC, S_SQRT, S_DIV_START, S_DIV, S_NORM, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        SRC_A, SRC_Q, SRC_AN, SRC_V, SRC_E, SRC_G, SRC_EI, SRC_C,
        SRC_DT, SRC_PG, SRC_KI, SRC_ACC
    } src_t;

    typedef enum logic [3:0] {
        WR_NONE, WR_SUM, WR_V29, WR_V30, WR_E, WR_EI, WR_TMP, WR_G, WR_C
    } wr_t;

    typedef struct packed {
        src_t       src_a;
        logic [1:0] ia;
        src_t       src_b;
        logic [1:0] ib;
        logic       first;
        logic       neg;
        wr_t        wr;
        logic [1:0] wi;
    } uop_t;

    localparam logic [5:0] STEP_PI      = 6'd0;
    localparam logic [5:0] STEP_D       = 6'd23;
    localparam logic [5:0] STEP_D_END   = 6'd38;
    localparam logic [5:0] STEP_CSQ     = 6'd39;
    localparam logic [5:0] STEP_CSQ_END = 6'd42;
    localparam logic [5:0] STEP_ASQ     = 6'd43;
    localparam logic [5:0] STEP_ASQ_END = 6'd45;

    state_t             state_reg;
    logic               quat_phase_reg;
    logic [1:0]         idx_reg;
    logic [5:0]         step_reg;
    logic               upd_reg;
    logic signed [31:0] q_reg  [4];
    logic signed [31:0] ei_reg [3];
    logic signed [31:0] g_reg  [3];
    logic signed [31:0] a_reg  [3];
    logic signed [31:0] an_reg [3];
    logic signed [33:0] v_reg  [3];
    logic signed [33:0] e_reg  [3];
    logic signed [63:0] c_reg  [4];
    logic [30:0]        dt_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] p_reg;
    logic signed [37:0] tmp_reg;
    logic [31:0]        root_reg;
    logic               m_valid_reg;
    logic [127:0]       m_data_reg;
    logic               m_user_reg;

    uop_t               u;
    logic signed [33:0] opa;
    logic signed [33:0] opb;
    logic signed [67:0] prod;
    logic signed [63:0] sum;
    logic signed [31:0] elem;
    logic [31:0]        elem_mag;
    logic               last_elem;
    logic               norm_done;
    logic               out_free;
    maf_ds_req_t        ds_req;
    logic [63:0]        ds_num;
    logic [31:0]        ds_den;
    logic               ds_done;
    logic [31:0]        ds_result;
    logic signed [31:0] quot_signed;

    function automatic uop_t mk(src_t sa, logic [1:0] ia, src_t sb, logic [1:0] ib,
                                logic first, logic neg, wr_t wr, logic [1:0] wi);
        uop_t r;
        r.src_a = sa;
        r.ia    = ia;
        r.src_b = sb;
        r.ib    = ib;
        r.first = first;
        r.neg   = neg;
        r.wr    = wr;
        r.wi    = wi;
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic in_range(logic signed [63:0] c);
        return (c[63:31] == '0) || ((c[63:31] == '1) && (c[30:0] != '0));
    endfunction

    function automatic logic signed [33:0] pick(src_t s, logic [1:0] i);
        logic signed [33:0] r;
        case (s)
            SRC_A:   r = 34'(a_reg[i]);
            SRC_Q:   r = 34'(q_reg[i]);
            SRC_AN:  r = 34'(an_reg[i]);
            SRC_V:   r = v_reg[i];
            SRC_E:   r = e_reg[i];
            SRC_G:   r = 34'(g_reg[i]);
            SRC_EI:  r = 34'(ei_reg[i]);
            SRC_C:   r = 34'($signed(c_reg[i][31:0]));
            SRC_DT:  r = {3'b0, dt_reg};
            SRC_PG:  r = {18'b0, gain.prop_gain};
            SRC_KI:  r = {18'b0, gain.integral_gain};
            SRC_ACC: r = acc_reg[63:30];
            default: r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        case (step_reg)
            6'd0:    u = mk(SRC_Q, 2'd1, SRC_Q, 2'd3, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd1:    u = mk(SRC_Q, 2'd0, SRC_Q, 2'd2, 1'b0, 1'b1, WR_V29, 2'd0);
            6'd2:    u = mk(SRC_Q, 2'd0, SRC_Q, 2'd1, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd3:    u = mk(SRC_Q, 2'd2, SRC_Q, 2'd3, 1'b0, 1'b0, WR_V29, 2'd1);
            6'd4:    u = mk(SRC_Q, 2'd0, SRC_Q, 2'd0, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd5:    u = mk(SRC_Q, 2'd1, SRC_Q, 2'd1, 1'b0, 1'b1, WR_NONE, 2'd0);
            6'd6:    u = mk(SRC_Q, 2'd2, SRC_Q, 2'd2, 1'b0, 1'b1, WR_NONE, 2'd0);
            6'd7:    u = mk(SRC_Q, 2'd3, SRC_Q, 2'd3, 1'b0, 1'b0, WR_V30, 2'd2);
            6'd8:    u = mk(SRC_AN, 2'd1, SRC_V, 2'd2, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd9:    u = mk(SRC_AN, 2'd2, SRC_V, 2'd1, 1'b0, 1'b1, WR_E, 2'd0);
            6'd10:   u = mk(SRC_AN, 2'd2, SRC_V, 2'd0, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd11:   u = mk(SRC_AN, 2'd0, SRC_V, 2'd2, 1'b0, 1'b1, WR_E, 2'd1);
            6'd12:   u = mk(SRC_AN, 2'd0, SRC_V, 2'd1, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd13:   u = mk(SRC_AN, 2'd1, SRC_V, 2'd0, 1'b0, 1'b1, WR_E, 2'd2);
            6'd14:   u = mk(SRC_E, 2'd0, SRC_DT, 2'd0, 1'b1, 1'b0, WR_EI, 2'd0);
            6'd15:   u = mk(SRC_E, 2'd1, SRC_DT, 2'd0, 1'b1, 1'b0, WR_EI, 2'd1);
            6'd16:   u = mk(SRC_E, 2'd2, SRC_DT, 2'd0, 1'b1, 1'b0, WR_EI, 2'd2);
            6'd17:   u = mk(SRC_PG, 2'd0, SRC_E, 2'd0, 1'b1, 1'b0, WR_TMP, 2'd0);
            6'd18:   u = mk(SRC_KI, 2'd0, SRC_EI, 2'd0, 1'b1, 1'b0, WR_G, 2'd0);
            6'd19:   u = mk(SRC_PG, 2'd0, SRC_E, 2'd1, 1'b1, 1'b0, WR_TMP, 2'd0);
            6'd20:   u = mk(SRC_KI, 2'd0, SRC_EI, 2'd1, 1'b1, 1'b0, WR_G, 2'd1);
            6'd21:   u = mk(SRC_PG, 2'd0, SRC_E, 2'd2, 1'b1, 1'b0, WR_TMP, 2'd0);
            6'd22:   u = mk(SRC_KI, 2'd0, SRC_EI, 2'd2, 1'b1, 1'b0, WR_G, 2'd2);
            6'd23:   u = mk(SRC_Q, 2'd1, SRC_G, 2'd0, 1'b1, 1'b1, WR_NONE, 2'd0);
            6'd24:   u = mk(SRC_Q, 2'd2, SRC_G, 2'd1, 1'b0, 1'b1, WR_NONE, 2'd0);
            6'd25:   u = mk(SRC_Q, 2'd3, SRC_G, 2'd2, 1'b0, 1'b1, WR_NONE, 2'd0);
            6'd26:   u = mk(SRC_ACC, 2'd0, SRC_DT, 2'd0, 1'b1, 1'b0, WR_C, 2'd0);
            6'd27:   u = mk(SRC_Q, 2'd0, SRC_G, 2'd0, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd28:   u = mk(SRC_Q, 2'd2, SRC_G, 2'd2, 1'b0, 1'b0, WR_NONE, 2'd0);
            6'd29:   u = mk(SRC_Q, 2'd3, SRC_G, 2'd1, 1'b0, 1'b1, WR_NONE, 2'd0);
            6'd30:   u = mk(SRC_ACC, 2'd0, SRC_DT, 2'd0, 1'b1, 1'b0, WR_C, 2'd1);
            6'd31:   u = mk(SRC_Q, 2'd0, SRC_G, 2'd1, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd32:   u = mk(SRC_Q, 2'd1, SRC_G, 2'd2, 1'b0, 1'b1, WR_NONE, 2'd0);
            6'd33:   u = mk(SRC_Q, 2'd3, SRC_G, 2'd0, 1'b0, 1'b0, WR_NONE, 2'd0);
            6'd34:   u = mk(SRC_ACC, 2'd0, SRC_DT, 2'd0, 1'b1, 1'b0, WR_C, 2'd2);
            6'd35:   u = mk(SRC_Q, 2'd0, SRC_G, 2'd2, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd36:   u = mk(SRC_Q, 2'd1, SRC_G, 2'd1, 1'b0, 1'b0, WR_NONE, 2'd0);
            6'd37:   u = mk(SRC_Q, 2'd2, SRC_G, 2'd0, 1'b0, 1'b1, WR_NONE, 2'd0);
            6'd38:   u = mk(SRC_ACC, 2'd0, SRC_DT, 2'd0, 1'b1, 1'b0, WR_C, 2'd3);
            6'd39:   u = mk(SRC_C, 2'd0, SRC_C, 2'd0, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd40:   u = mk(SRC_C, 2'd1, SRC_C, 2'd1, 1'b0, 1'b0, WR_NONE, 2'd0);
            6'd41:   u = mk(SRC_C, 2'd2, SRC_C, 2'd2, 1'b0, 1'b0, WR_NONE, 2'd0);
            6'd42:   u = mk(SRC_C, 2'd3, SRC_C, 2'd3, 1'b0, 1'b0, WR_SUM, 2'd0);
            6'd43:   u = mk(SRC_A, 2'd0, SRC_A, 2'd0, 1'b1, 1'b0, WR_NONE, 2'd0);
            6'd44:   u = mk(SRC_A, 2'd1, SRC_A, 2'd1, 1'b0, 1'b0, WR_NONE, 2'd0);
            6'd45:   u = mk(SRC_A, 2'd2, SRC_A, 2'd2, 1'b0, 1'b0, WR_SUM, 2'd0);
            default: u = mk(SRC_DT, 2'd0, SRC_DT, 2'd0, 1'b1, 1'b0, WR_NONE, 2'd0);
        endcase
    end

    always_comb begin
        opa = pick(u.src_a, u.ia);
        opb = pick(u.src_b, u.ib);
    end

    assign prod = opa * opb;

    always_comb begin
        if (u.first) begin
            sum = u.neg ? -p_reg : p_reg;
        end else begin
            sum = u.neg ? acc_reg - p_reg : acc_reg + p_reg;
        end
    end

    always_comb begin
        case (idx_reg)
            2'd0:    elem = quat_phase_reg ? c_reg[0][31:0] : a_reg[0];
            2'd1:    elem = quat_phase_reg ? c_reg[1][31:0] : a_reg[1];
            2'd2:    elem = quat_phase_reg ? c_reg[2][31:0] : a_reg[2];
            default: elem = c_reg[3][31:0];
        endcase
    end

    assign elem_mag    = elem[31] ? 32'(-elem) : elem;
    assign last_elem   = quat_phase_reg ? (idx_reg == 2'd3) : (idx_reg == 2'd2);
    assign quot_signed = elem[31] ? -$signed(ds_result) : $signed(ds_result);
    assign norm_done   = in_range(c_reg[0]) && in_range(c_reg[1])
                         && in_range(c_reg[2]) && in_range(c_reg[3]);
    assign out_free    = !m_valid_reg || m_tready;

    assign pop = (state_reg == S_IDLE) && !empty;

    always_comb begin
        ds_req.start   = 1'b0;
        ds_req.is_sqrt = 1'b0;
        ds_num         = {4'b0, head.delta, 30'b0};
        ds_den         = {2'b0, NS_PER_S};
        case (state_reg)
            S_IDLE: begin
                ds_req.start = !empty && head.updated;
            end
            S_ACC: begin
                ds_req.start   = ((step_reg == STEP_ASQ_END) || (step_reg == STEP_CSQ_END))
                                 && (sum != '0);
                ds_req.is_sqrt = 1'b1;
                ds_num         = sum;
            end
            S_DIV_START: begin
                ds_req.start = 1'b1;
                ds_num       = {2'b0, elem_mag, 30'b0};
                ds_den       = root_reg;
            end
            default: begin
                ds_req.start = 1'b0;
            end
        endcase
    end

    maf_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ds_req),
        .num     (ds_num),
        .den     (ds_den),
        .done    (ds_done),
        .result  (ds_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            quat_phase_reg <= 1'b0;
            idx_reg        <= '0;
            step_reg       <= '0;
            m_valid_reg    <= 1'b0;
            q_reg[0]       <= Q30_ONE;
            q_reg[1]       <= '0;
            q_reg[2]       <= '0;
            q_reg[3]       <= '0;
            ei_reg[0]      <= '0;
            ei_reg[1]      <= '0;
            ei_reg[2]      <= '0;
        end else begin
            if (m_valid_reg && m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (!empty) begin
                        upd_reg <= head.updated;
                        for (int i = 0; i < 3; i++) begin
                            g_reg[i] <= head.gyro[i];
                            a_reg[i] <= head.accel[i];
                        end
                        state_reg <= head.updated ? S_DT : S_OUT;
                    end
                end
                S_DT: begin
                    if (ds_done) begin
                        dt_reg    <= ds_result[30:0];
                        step_reg  <= STEP_ASQ;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    p_reg     <= prod[63:0];
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= sum;
                    case (u.wr)
                        WR_V29:  v_reg[u.wi] <= sum[62:29];
                        WR_V30:  v_reg[u.wi] <= sum[63:30];
                        WR_E:    e_reg[u.wi] <= sum[63:30];
                        WR_EI:   ei_reg[u.wi] <= sat32(64'(ei_reg[u.wi]) + (sum >>> 44));
                        WR_TMP:  tmp_reg <= sum[63:26];
                        WR_G:    g_reg[u.wi] <= sat32(64'(g_reg[u.wi]) + 64'(tmp_reg)
                                                      + (sum >>> 12));
                        WR_C:    c_reg[u.wi] <= 64'(q_reg[u.wi]) + (sum >>> 17);
                        default: ;
                    endcase
                    if (step_reg == STEP_ASQ_END) begin
                        if (sum == '0) begin
                            step_reg  <= STEP_D;
                            state_reg <= S_MUL;
                        end else begin
                            quat_phase_reg <= 1'b0;
                            state_reg      <= S_SQRT;
                        end
                    end else if (step_reg == STEP_CSQ_END) begin
                        if (sum == '0) begin
                            for (int i = 0; i < 4; i++) begin
                                q_reg[i] <= '0;
                            end
                            state_reg <= S_OUT;
                        end else begin
                            quat_phase_reg <= 1'b1;
                            state_reg      <= S_SQRT;
                        end
                    end else if (step_reg == STEP_D_END) begin
                        state_reg <= S_NORM;
                    end else begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_SQRT: begin
                    if (ds_done) begin
                        root_reg  <= ds_result;
                        idx_reg   <= '0;
                        state_reg <= S_DIV_START;
                    end
                end
                S_DIV_START: begin
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (ds_done) begin
                        if (quat_phase_reg) begin
                            q_reg[idx_reg] <= quot_signed;
                        end else begin
                            an_reg[idx_reg] <= quot_signed;
                        end
                        if (!last_elem) begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DIV_START;
                        end else if (quat_phase_reg) begin
                            state_reg <= S_OUT;
                        end else begin
                            step_reg  <= STEP_PI;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_NORM: begin
                    if (norm_done) begin
                        step_reg  <= STEP_CSQ;
                        state_reg <= S_MUL;
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            c_reg[i] <= c_reg[i] >>> 1;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
                        m_user_reg  <= upd_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- tb/sv/tb_mahony_attitude_filter.sv -----
// Self-checking bench for mahony_attitude_filter: streams IMU samples, predicts
// each attitude beat with a fixed-point filter model and compares field by field.
// Depends on maf_pkg and the mahony_attitude_filter RTL.
module tb_mahony_attitude_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import maf_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [3:0][31:0] quat;
        logic             updated;
    } attitude_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    mahony_attitude_filter dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 aclk = ~aclk;

    // filter model state
    longint          held_quat[4];
    longint          drift_sum[3];
    longint unsigned last_stamp;
    bit              seen_stamp;
    longint unsigned gain_p, gain_i, gap_limit;

    attitude_beat_t  pending_attitude[$];
    bit              failed = 1'b0;
    int              idle_cycles = 0;
    int              hold_cycles = 0;
    int              rx_gap = 0;
    bit              rx_chop = 1'b0;
    bit              tx_chop = 1'b0;
    longint unsigned stamp_base = 0;

    function automatic longint unsigned magn(longint x);
        return x < 0 ? 64'd0 - longint'(x) : x;
    endfunction

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint scale_q30(longint c, longint unsigned r);
        longint unsigned q;
        q = (magn(c) << 30) / r;
        return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic attitude_beat_t advance_attitude(logic [255:0] beat);
        attitude_beat_t  res;
        longint unsigned st, delta, s, r, m;
        longint          dt, qw, qx, qy, qz;
        longint          g[3], a[3], an[3], v[3], e[3], c[4], d[4];
        st = {1'b0, beat[62:0]};
        delta = 0;
        if (seen_stamp && st > last_stamp) begin
            delta = st - last_stamp;
            if (delta > gap_limit) delta = 0;
        end
        last_stamp = st;
        seen_stamp = 1'b1;
        if (delta != 0) begin
            dt = longint'((delta << 30) / 64'd1000000000);
            qw = held_quat[0]; qx = held_quat[1]; qy = held_quat[2]; qz = held_quat[3];
            for (int i = 0; i < 3; i++) begin
                g[i] = $signed(beat[63 + 32*i +: 32]);
                a[i] = $signed(beat[159 + 32*i +: 32]);
            end
            s = longint'(a[0]*a[0]) + longint'(a[1]*a[1]) + longint'(a[2]*a[2]);
            if (s != 0) begin
                r = int_sqrt(s);
                for (int i = 0; i < 3; i++) an[i] = scale_q30(a[i], r);
                v[0] = (qx*qz - qw*qy) >>> 29;
                v[1] = (qw*qx + qy*qz) >>> 29;
                v[2] = (qw*qw - qx*qx - qy*qy + qz*qz) >>> 30;
                e[0] = (an[1]*v[2] - an[2]*v[1]) >>> 30;
                e[1] = (an[2]*v[0] - an[0]*v[2]) >>> 30;
                e[2] = (an[0]*v[1] - an[1]*v[0]) >>> 30;
                for (int i = 0; i < 3; i++) begin
                    drift_sum[i] = sat32(drift_sum[i] + ((e[i]*dt) >>> 44));
                    g[i] = sat32(g[i] + ((longint'(gain_p)*e[i]) >>> 26)
                                 + ((longint'(gain_i)*drift_sum[i]) >>> 12));
                end
            end
            d[0] = -qx*g[0] - qy*g[1] - qz*g[2];
            d[1] = qw*g[0] + qy*g[2] - qz*g[1];
            d[2] = qw*g[1] - qx*g[2] + qz*g[0];
            d[3] = qw*g[2] + qx*g[1] - qy*g[0];
            for (int i = 0; i < 4; i++) c[i] = held_quat[i] + (((d[i] >>> 30)*dt) >>> 17);
            forever begin
                m = 0;
                for (int i = 0; i < 4; i++) if (magn(c[i]) > m) m = magn(c[i]);
                if (m < 64'h8000_0000) break;
                for (int i = 0; i < 4; i++) c[i] = c[i] >>> 1;
            end
            s = 0;
            for (int i = 0; i < 4; i++) s = s + longint'(c[i]*c[i]);
            if (s != 0) begin
                r = int_sqrt(s);
                for (int i = 0; i < 4; i++) held_quat[i] = scale_q30(c[i], r);
            end else begin
                for (int i = 0; i < 4; i++) held_quat[i] = 0;
            end
        end
        for (int i = 0; i < 4; i++) res.quat[i] = held_quat[i][31:0];
        res.updated = delta != 0;
        return res;
    endfunction

    // check result beats and watch for a hang
    always @(posedge aclk) begin
        attitude_beat_t want;
        string          names[4];
        names = '{"quat_w", "quat_x", "quat_y", "quat_z"};
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_attitude.size() == 0) begin
                $error("result beat with no sample pending: %h", m_tdata);
                failed = 1'b1;
            end else begin
                want = pending_attitude.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[32*i +: 32] !== want.quat[i]) begin
                        $error("%s: expected %h, got %h", names[i], want.quat[i],
                               m_tdata[32*i +: 32]);
                        failed = 1'b1;
                    end
                if (m_tuser !== want.updated) begin
                    $error("updated: expected %b, got %b", want.updated, m_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    // result side: random stalls plus commanded long hold
    initial forever begin
        @(negedge aclk);
        if (hold_cycles > 0) begin
            m_tready = 1'b0;
            hold_cycles--;
        end else if (rx_gap > 0) begin
            m_tready = 1'b0;
            rx_gap--;
        end else begin
            m_tready = 1'b1;
            if (rx_chop && $urandom_range(0, 5) == 0)
                rx_gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 3);
        end
    end

    task automatic send_sample(logic [62:0] stamp, logic [31:0] gx, logic [31:0] gy,
                               logic [31:0] gz, logic [31:0] ax, logic [31:0] ay,
                               logic [31:0] az);
        int             gap;
        attitude_beat_t expect_beat;
        gap = 0;
        if (tx_chop && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {1'b0, az, ay, ax, gz, gy, gx, stamp};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expect_beat = advance_attitude(s_tdata);
        pending_attitude = {pending_attitude, expect_beat};
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_attitude.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(maf_reg_t idx, logic [31:0] value);
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = {idx, 2'b00}; pwdata = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_PROP_GAIN:     gain_p = value[15:0];
            REG_INTEGRAL_GAIN: gain_i = value[15:0];
            REG_MAX_GAP:       gap_limit = value[DELTA_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_random;
        logic [62:0] st;
        logic [31:0] g[3], a[3];
        int          kind;
        longint unsigned span;
        kind = $urandom_range(0, 99);
        span = (gap_limit == 0) ? 1000 : gap_limit;
        if (kind < 82) begin
            if ($urandom_range(0, 9) == 0) st = stamp_base + $urandom_range(1, span);
            else st = stamp_base + $urandom_range(1, (span < 20000000) ? span : 20000000);
            for (int i = 0; i < 3; i++) begin
                g[i] = $signed($urandom_range(0, 600000)) - 300000;
                a[i] = $signed($urandom_range(0, 400000)) - 200000;
            end
            a[2] = a[2] + 32'sd642000;
            if ($urandom_range(0, 19) == 0) a = '{32'd0, 32'd0, 32'd0};
        end else begin
            case ($urandom_range(0, 3))
                0: st = stamp_base;
                1: st = stamp_base - $urandom_range(1, 1000000);
                2: st = stamp_base + span + $urandom_range(1, 1000);
                default: st = {$urandom(), $urandom()};
            endcase
            for (int i = 0; i < 3; i++) begin
                g[i] = $urandom();
                a[i] = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
            end
        end
        stamp_base = st;
        send_sample(st, g[0], g[1], g[2], a[0], a[1], a[2]);
    endtask

    task automatic test_directed;
        send_sample(63'd1000, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd642000);
        send_sample(63'd1000, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd642000);
        send_sample(63'd500, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd642000);
        send_sample(63'd100000500, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd642000);
        send_sample(63'd200000501, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd642000);
        send_sample(63'd210000000, 32'd131072, 32'hFFFF0000, 32'd40000, 32'd0, 32'd0, 32'd0);
        send_sample(63'd220000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        send_sample(63'd230000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                    32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_sample(63'd240000000, 32'hFFFFFFFF, 32'd1, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd0);
        send_sample(63'd250000000, 32'd0, 32'd0, 32'd0, 32'd642000, 32'd0, 32'd0);
        send_sample(63'd250000001, 32'd0, 32'd300000, 32'd0, 32'd0, 32'h80000000, 32'd0);
        send_sample({63{1'b1}}, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
                    32'h55555555, 32'hAAAAAAAA, 32'h55555555);
        send_sample(63'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(63'd50000000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        stamp_base = 63'd50000000;
        drain();
    endtask

    task automatic test_config_sweep;
        write_reg(REG_MAX_GAP, 32'd0);
        repeat (8) send_random();
        drain();
        write_reg(REG_PROP_GAIN, 32'd0);
        write_reg(REG_INTEGRAL_GAIN, 32'd65535);
        write_reg(REG_MAX_GAP, 32'd1000000000);
        repeat (60) send_random();
        drain();
        write_reg(REG_PROP_GAIN, 32'd65535);
        write_reg(REG_INTEGRAL_GAIN, 32'd0);
        write_reg(REG_MAX_GAP, 32'd1);
        repeat (20) send_random();
        drain();
        write_reg(REG_PROP_GAIN, 32'd4096);
        write_reg(REG_INTEGRAL_GAIN, 32'd400);
        write_reg(REG_MAX_GAP, 32'd50000000);
        repeat (60) send_random();
        drain();
    endtask

    task automatic test_backpressure;
        tx_chop = 1'b0;
        hold_cycles = 1500;
        repeat (12) send_random();
        drain();
    endtask

    task automatic test_random;
        for (int n = 0; n < 1500; n++) begin
            if (n % 300 == 0) begin
                rx_chop = (n % 600 == 0);
                tx_chop = (n % 900 != 0);
            end
            send_random();
        end
        drain();
    endtask

    initial begin
        gain_p = PROP_GAIN_RST;
        gain_i = INTEGRAL_GAIN_RST;
        gap_limit = MAX_GAP_RST;
        held_quat = '{64'd1 << 30, 0, 0, 0};
        drift_sum = '{0, 0, 0};
        last_stamp = 0;
        seen_stamp = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        rx_chop = 1'b1;
        tx_chop = 1'b1;
        test_config_sweep();
        test_backpressure();
        test_random();
        repeat (300) @(posedge aclk);
        if (!failed && pending_attitude.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/maf_pkg.sv
hdl/maf_fifo.sv
hdl/maf_front.sv
hdl/maf_divsqrt.sv
hdl/maf_core.sv
hdl/mahony_attitude_filter.sv
tb/sv/tb_mahony_attitude_filter.sv
